[rtl/cktm_pkg.sv]
// ----------------------------------------------------------------------------
// cktm_pkg
// Shared types, constants and the card slot builder for the key table matcher.
// ----------------------------------------------------------------------------
package cktm_pkg;

   localparam int SLOT_BITS  = 64;
   localparam int ASM_BITS   = 56;
   localparam int UID_BYTES  = 7;
   localparam logic [7:0] CSUM_SEED = 8'h0F;

   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_CHECK   = 2'd1,
      MODE_RESTART = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_DONE
   } state_type;

   // reverse the uid into slot byte order, zero pad, append the checksum byte
   function automatic logic [SLOT_BITS-1:0] form_card(input logic [ASM_BITS-1:0] uid,
                                                       input logic [2:0] len);
      logic [ASM_BITS-1:0] card;
      logic [7:0]          s1;
      logic [3:0]          s2;
      logic [2:0]          src;
      card = '0;
      s1   = CSUM_SEED;
      s2   = CSUM_SEED[3:0];
      src  = '0;
      for (int p = 0; p < UID_BYTES; p++) begin
         if (3'(p) < len) begin
            src = len - 3'd1 - 3'(p);
            card[8*p +: 8] = uid[8*src +: 8];
         end
      end
      for (int p = 0; p < UID_BYTES; p++) begin
         s1 = s1 + card[8*p +: 8];
         s2 = s2 + s1[3:0];
      end
      return {s2 | s1[7:4], s1[3:0], card};
   endfunction

endpackage

[rtl/card_key_table_matcher.sv]
// ----------------------------------------------------------------------------
// card_key_table_matcher
// Key slot table in one synchronous memory, loaded byte by byte and scanned
// in full for every card check.
//
//   channel | dir | ports                                   | handshake
//   req     | in  | mode, load_byte, uid_bytes, uid_length  | req_valid / req_stall
//   rsp     | out | match, slot_written, load_complete      | rsp_valid / rsp_stall
//
// Load, restart and unused-mode items are answered from idle; a check scans
// every slot, one memory read per slot via the single read port, no early exit.
// Slots are written as a prefix from slot 0, so a fill count marks erased slots;
// there is no clearing pass and the block is ready in the cycle after reset.
// A result waits in the output register under rsp_stall; the next item is taken
// in the same cycle the waiting result leaves.
// ----------------------------------------------------------------------------
module card_key_table_matcher
   import cktm_pkg::*;
#(
   parameter int NUM_SLOTS = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic [7:0]          req_load_byte,
   input  logic [ASM_BITS-1:0] req_uid_bytes,
   input  logic [2:0]          req_uid_length,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_match,
   output logic                rsp_slot_written,
   output logic                rsp_load_complete
);

   localparam int PTR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(NUM_SLOTS - 1);

   logic [SLOT_BITS-1:0] mem [NUM_SLOTS];

   state_type            state_ff, state_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic [2:0]           pos_ff, pos_in;
   logic [ASM_BITS-1:0]  asm_ff, asm_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [SLOT_BITS-1:0] card_ff, card_in;
   logic [PTR_W-1:0]     scan_ff, scan_in;
   logic [SLOT_BITS-1:0] rd_data_ff;
   logic [PTR_W-1:0]     rd_idx_ff;
   logic                 rd_live_ff, rd_live_in;
   logic                 hit_ff, hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 match_ff, match_in;
   logic                 written_ff, written_in;
   logic                 complete_ff, complete_in;

   logic                 mem_we;
   logic [SLOT_BITS-1:0] mem_wdata;
   logic                 out_free;
   logic                 accept;
   logic [SLOT_BITS-1:0] slot_val;
   logic                 slot_eq;
   logic [CNT_W-1:0]     next_fill;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   assign slot_val  = (CNT_W'(rd_idx_ff) < fill_ff) ? rd_data_ff : '1;
   assign slot_eq   = rd_live_ff && (slot_val == card_ff);
   assign next_fill = CNT_W'(ptr_ff) + CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      asm_in       = asm_ff;
      fill_in      = fill_ff;
      card_in      = card_ff;
      scan_in      = scan_ff;
      rd_live_in   = 1'b0;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      match_in     = match_ff;
      written_in   = written_ff;
      complete_in  = complete_ff;
      mem_we       = 1'b0;
      mem_wdata    = {req_load_byte, asm_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               match_in    = 1'b0;
               written_in  = 1'b0;
               complete_in = 1'b0;
               unique case (mode_type'(req_mode))
                  MODE_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (pos_ff == 3'd7) begin
                        mem_we     = 1'b1;
                        asm_in     = '0;
                        pos_in     = '0;
                        written_in = 1'b1;
                        if (next_fill > fill_ff) begin
                           fill_in = next_fill;
                        end
                        if (ptr_ff == LAST_SLOT) begin
                           ptr_in      = '0;
                           complete_in = 1'b1;
                        end else begin
                           ptr_in = ptr_ff + PTR_W'(1);
                        end
                     end else begin
                        asm_in = asm_ff | (ASM_BITS'(req_load_byte) << {pos_ff, 3'b000});
                        pos_in = pos_ff + 3'd1;
                     end
                  end
                  MODE_CHECK: begin
                     card_in  = form_card(req_uid_bytes, req_uid_length);
                     hit_in   = 1'b0;
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
                  MODE_RESTART: begin
                     rsp_valid_in = 1'b1;
                     ptr_in       = '0;
                     pos_in       = '0;
                     asm_in       = '0;
                  end
                  MODE_NONE: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_live_in = 1'b1;
            hit_in     = hit_ff | slot_eq;
            scan_in    = scan_ff + PTR_W'(1);
            if (scan_ff == LAST_SLOT) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            hit_in   = hit_ff | slot_eq;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               match_in     = hit_ff;
               written_in   = 1'b0;
               complete_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         pos_ff       <= '0;
         asm_ff       <= '0;
         fill_ff      <= '0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         pos_ff       <= pos_in;
         asm_ff       <= asm_in;
         fill_ff      <= fill_in;
         rd_live_ff   <= rd_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      card_ff     <= card_in;
      scan_ff     <= scan_in;
      rd_idx_ff   <= scan_ff;
      hit_ff      <= hit_in;
      match_ff    <= match_in;
      written_ff  <= written_in;
      complete_ff <= complete_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ptr_ff] <= mem_wdata;
      end
      rd_data_ff <= mem[scan_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match         = match_ff;
   assign rsp_slot_written  = written_ff;
   assign rsp_load_complete = complete_ff;

endmodule

[rtl/cktm_checker.sv]
// ----------------------------------------------------------------------------
// cktm_checker
// Port-level checks for the card key table matcher.
// ----------------------------------------------------------------------------
module cktm_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_match,
   input logic rsp_slot_written,
   input logic rsp_load_complete
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_match_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_match && rsp_slot_written))
      else $error("match and slot write in one item");

   a_complete_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_load_complete |-> rsp_slot_written)
      else $error("load complete without slot write");

endmodule

bind card_key_table_matcher cktm_checker u_cktm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_match         (rsp_match),
   .rsp_slot_written  (rsp_slot_written),
   .rsp_load_complete (rsp_load_complete)
);
